### sv/q4bd_pkg.sv
// ----------------------------------------------------------------------------
// q4bd_pkg
// Shared types and constants for the 4-bit block dot row accumulator.
// ----------------------------------------------------------------------------
package q4bd_pkg;

  localparam int BLOCK_ELEMENTS = 32;
  localparam int LANE_ELEMS     = 8;
  localparam int LANES          = BLOCK_ELEMENTS / LANE_ELEMS;

  localparam int NIB_W      = 4;
  localparam int ACT_W      = 8;
  localparam int WORD_W     = 64;
  localparam int LANE_NIB_W = LANE_ELEMS * NIB_W;
  localparam int EPROD_W    = 13;  // nibble (0..15) times int8
  localparam int LANE_SUM_W = 15;  // |sum of 8 products| < 2^14
  localparam int MSUM_W     = 17;  // sum of four lanes
  localparam int ASUM_W     = 13;
  localparam int DOT_W      = 18;  // |dot| < 2^17
  localparam int SCALE_W    = 32;
  localparam int PROD_W     = DOT_W + SCALE_W;
  localparam int ACC_W      = 64;

  localparam int IN_TDATA_W  = 432;  // 429 field bits padded to 54 bytes
  localparam int OUT_TDATA_W = 64;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef logic signed [LANE_SUM_W-1:0] lane_sum_t;
  typedef logic signed [PROD_W-1:0]     prod_t;

  typedef struct packed {
    logic valid;
    logic last;
  } ctl_t;

endpackage

### sv/q4bd_lane.sv
// ----------------------------------------------------------------------------
// q4bd_lane
// One lane: dot of eight unsigned nibbles with eight int8 activations.
// ----------------------------------------------------------------------------
module q4bd_lane (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic [q4bd_pkg::LANE_NIB_W-1:0]      nib_i,
  input  logic [q4bd_pkg::WORD_W-1:0]          act_i,
  output q4bd_pkg::lane_sum_t                  sum_o
);

  q4bd_pkg::lane_sum_t sum_d, sum_q;

  always_comb begin
    logic signed [q4bd_pkg::EPROD_W-1:0] p;
    logic        [q4bd_pkg::ACT_W-1:0]   a;
    sum_d = '0;
    for (int e = 0; e < q4bd_pkg::LANE_ELEMS; e++) begin
      a = act_i[e*q4bd_pkg::ACT_W +: q4bd_pkg::ACT_W];
      p = signed'({9'd0, nib_i[e*q4bd_pkg::NIB_W +: q4bd_pkg::NIB_W]})
          * signed'({{5{a[7]}}, a});
      sum_d = sum_d + q4bd_pkg::LANE_SUM_W'(p);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

### sv/q4bd_merge.sv
// ----------------------------------------------------------------------------
// q4bd_merge
// Combines lane sums, removes the 8 * activation_sum offset, then scales.
// Two register stages: dot, then dot * scale.
// ----------------------------------------------------------------------------
module q4bd_merge (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  q4bd_pkg::ctl_t                      ctl_i,
  input  q4bd_pkg::lane_sum_t                 lane_sum_i [q4bd_pkg::LANES],
  input  logic signed [q4bd_pkg::ASUM_W-1:0]  asum_i,
  input  logic signed [q4bd_pkg::SCALE_W-1:0] scale_i,
  output q4bd_pkg::ctl_t                      ctl_o,
  output q4bd_pkg::prod_t                     prod_o
);

  logic signed [q4bd_pkg::DOT_W-1:0]   dot_d, dot_q;
  logic signed [q4bd_pkg::SCALE_W-1:0] scale_q;
  q4bd_pkg::ctl_t                      ctl2_q, ctl3_q;
  q4bd_pkg::prod_t                     prod_q;

  always_comb begin
    logic signed [q4bd_pkg::MSUM_W-1:0] msum;
    msum = '0;
    for (int k = 0; k < q4bd_pkg::LANES; k++) begin
      msum = msum + q4bd_pkg::MSUM_W'(lane_sum_i[k]);
    end
    dot_d = q4bd_pkg::DOT_W'(msum)
          - q4bd_pkg::DOT_W'(signed'({asum_i, 3'b000}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl2_q <= '0;
      ctl3_q <= '0;
    end else if (en_i) begin
      ctl2_q <= ctl_i;
      ctl3_q <= ctl2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dot_q   <= dot_d;
      scale_q <= scale_i;
      prod_q  <= q4bd_pkg::PROD_W'(dot_q) * q4bd_pkg::PROD_W'(scale_q);
    end
  end

  assign ctl_o  = ctl3_q;
  assign prod_o = prod_q;

endmodule

### sv/q4bd_accum.sv
// ----------------------------------------------------------------------------
// q4bd_accum
// Saturating row accumulator with clip flag and the result register.
// ----------------------------------------------------------------------------
module q4bd_accum (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  q4bd_pkg::ctl_t                         ctl_i,
  input  q4bd_pkg::prod_t                        prod_i,
  output logic                                   hold_o,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [q4bd_pkg::ACC_W-1:0]             row_sum_o,
  output logic                                   saturated_o
);

  logic signed [q4bd_pkg::ACC_W-1:0] acc_d, acc_q, sat_sum;
  logic signed [q4bd_pkg::ACC_W:0]   wide_sum;
  logic                              clip_d, clip_q, ovf;
  logic                              out_valid_d, out_valid_q;
  logic [q4bd_pkg::ACC_W-1:0]        row_sum_q;
  logic                              sat_q;
  logic                              take;

  // A finished row can only leave when the result register is free.
  assign hold_o = ctl_i.valid && ctl_i.last && out_valid_q && !out_ready_i;
  assign take   = ctl_i.valid && !hold_o;

  always_comb begin
    wide_sum = (q4bd_pkg::ACC_W+1)'(acc_q) + (q4bd_pkg::ACC_W+1)'(prod_i);
    ovf      = wide_sum[q4bd_pkg::ACC_W] ^ wide_sum[q4bd_pkg::ACC_W-1];
    if (ovf) begin
      sat_sum = wide_sum[q4bd_pkg::ACC_W] ? q4bd_pkg::ACC_MIN : q4bd_pkg::ACC_MAX;
    end else begin
      sat_sum = wide_sum[q4bd_pkg::ACC_W-1:0];
    end

    acc_d       = acc_q;
    clip_d      = clip_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (take) begin
      if (ctl_i.last) begin
        acc_d       = '0;
        clip_d      = 1'b0;
        out_valid_d = 1'b1;
      end else begin
        acc_d  = sat_sum;
        clip_d = clip_q || ovf;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      clip_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      clip_q      <= clip_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && ctl_i.last) begin
      row_sum_q <= sat_sum;
      sat_q     <= clip_q || ovf;
    end
  end

  assign out_valid_o = out_valid_q;
  assign row_sum_o   = row_sum_q;
  assign saturated_o = sat_q;

`ifndef SYNTHESIS
  a_hold_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_o |-> out_valid_q)
    else $error("stall raised with empty result register");

  a_row_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && ctl_i.last) |=> (acc_q == '0 && !clip_q))
    else $error("accumulator not cleared after row end");

  a_clip_at_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(clip_q) |-> (acc_q == q4bd_pkg::ACC_MAX || acc_q == q4bd_pkg::ACC_MIN))
    else $error("clip flag set without a saturated accumulator");

  a_no_result_midrow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.valid && !ctl_i.last) |=> !$rose(out_valid_q))
    else $error("result produced by a block that does not end the row");
`endif

endmodule

### sv/q4_block_dot_row_accumulator.sv
// ----------------------------------------------------------------------------
// q4_block_dot_row_accumulator
// Four-bit weight block dot product with saturating Q39.24 row accumulation.
// ----------------------------------------------------------------------------
// A row's last block: lane, dot, product regs, then m_axis_tvalid register.
// Throughput: one block per cycle unless stalled; four lanes of 8 elements.
// The pipeline stalls only while a row result waits in the output register
// and the next row end reaches the accumulator stage.
// Reset (rst_ni low, async) clears the accumulator, clip flag and all valids.
module q4_block_dot_row_accumulator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // nibbles_low_word[63:0], nibbles_high_word[127:64], act_word_a[191:128],
  // act_word_b[255:192], act_word_c[319:256], act_word_d[383:320],
  // activation_sum[396:384], block_scale[428:397], zero pad[431:429]
  input  logic [q4bd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  logic                                s_axis_tlast,   // last_block
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [q4bd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // row_sum[63:0]
  output logic                                m_axis_tuser    // saturated
);

  logic                                advance;
  logic                                hold;
  logic [q4bd_pkg::WORD_W-1:0]         wq [2];
  logic [q4bd_pkg::LANE_NIB_W-1:0]     lane_nib [q4bd_pkg::LANES];
  q4bd_pkg::lane_sum_t                 lane_sum [q4bd_pkg::LANES];
  logic signed [q4bd_pkg::ASUM_W-1:0]  asum_q;
  logic signed [q4bd_pkg::SCALE_W-1:0] scale_q;
  q4bd_pkg::ctl_t                      ctl1_q, ctl1_d, ctl_acc;
  q4bd_pkg::prod_t                     prod;

  assign advance       = !hold;
  assign s_axis_tready = advance;

  assign wq[0] = s_axis_tdata[63:0];
  assign wq[1] = s_axis_tdata[127:64];

  // Lane k: weight word k%2, low nibbles for k<2, high nibbles otherwise.
  for (genvar k = 0; k < q4bd_pkg::LANES; k++) begin : g_lane
    for (genvar b = 0; b < q4bd_pkg::LANE_ELEMS; b++) begin : g_nib
      assign lane_nib[k][b*q4bd_pkg::NIB_W +: q4bd_pkg::NIB_W] =
        wq[k % 2][b*8 + q4bd_pkg::NIB_W*(k/2) +: q4bd_pkg::NIB_W];
    end

    q4bd_lane u_lane (
      .clk_i (clk_i),
      .en_i  (advance),
      .nib_i (lane_nib[k]),
      .act_i (s_axis_tdata[128 + k*q4bd_pkg::WORD_W +: q4bd_pkg::WORD_W]),
      .sum_o (lane_sum[k])
    );
  end

  always_comb begin
    ctl1_d.valid = s_axis_tvalid;
    ctl1_d.last  = s_axis_tlast;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
    end else if (advance) begin
      ctl1_q <= ctl1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      asum_q  <= s_axis_tdata[396:384];
      scale_q <= s_axis_tdata[428:397];
    end
  end

  q4bd_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (advance),
    .ctl_i      (ctl1_q),
    .lane_sum_i (lane_sum),
    .asum_i     (asum_q),
    .scale_i    (scale_q),
    .ctl_o      (ctl_acc),
    .prod_o     (prod)
  );

  q4bd_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl_acc),
    .prod_i      (prod),
    .hold_o      (hold),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .row_sum_o   (m_axis_tdata),
    .saturated_o (m_axis_tuser)
  );

endmodule

### verif/q4_block_dot_row_accumulator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// q4_block_dot_row_accumulator_tb
// Streams weight blocks into the row accumulator and checks every row result
// against a cycle-free predictor: directed corner blocks, long rows of the
// large products of both signs, then random rows under several idle/stall
// mixes.
// ----------------------------------------------------------------------------
module q4_block_dot_row_accumulator_tb;

  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic [63:0]        nib_lo;
    logic [63:0]        nib_hi;
    logic [63:0]        act[4];
    logic signed [12:0] asum;
    logic signed [31:0] scale;
    logic               last;
  } blk_t;

  typedef struct packed {
    logic [63:0] row_sum;
    logic        sat;
  } row_result_t;

  logic                             clk_i         = 1'b0;
  logic                             rst_ni        = 1'b0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [q4bd_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                             s_axis_tlast  = 1'b0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [q4bd_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                             m_axis_tuser;

  // predictor state
  logic signed [63:0] row_acc  = '0;
  logic               row_clip = 1'b0;
  row_result_t        pending_rows[$];

  int idle_pct     = 0;
  int stall_pct    = 0;
  int mismatch_cnt = 0;
  int quiet_cycles = 0;
  row_result_t exp_row;

  q4_block_dot_row_accumulator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  // one block into the row accumulator; one result per finished row
  function automatic void accumulate_block(input blk_t b);
    int                 s1;
    int                 bi;
    logic [63:0]        wq;
    logic [3:0]         nv;
    byte                av;
    longint             dot;
    longint             prod;
    logic [64:0]        total;
    s1 = 0;
    for (int i = 0; i < q4bd_pkg::BLOCK_ELEMENTS; i++) begin
      bi = i % 16;
      wq = (bi < 8) ? b.nib_lo : b.nib_hi;
      // byte j: low nibble is element j, high nibble is element j+16
      nv = wq[(bi % 8) * 8 + ((i >= 16) ? 4 : 0) +: 4];
      av = b.act[i / 8][(i % 8) * 8 +: 8];
      s1 += int'(nv) * int'(av);
    end
    dot   = longint'(s1) - 8 * longint'(b.asum);
    prod  = dot * longint'(b.scale);
    total = {row_acc[63], row_acc} + {prod[63], prod};
    if (total[64] != total[63]) begin
      row_acc  = total[64] ? q4bd_pkg::ACC_MIN : q4bd_pkg::ACC_MAX;
      row_clip = 1'b1;
    end else begin
      row_acc = total[63:0];
    end
    if (b.last) begin
      pending_rows.push_back('{row_sum: row_acc, sat: row_clip});
      row_acc  = '0;
      row_clip = 1'b0;
    end
  endfunction

  function automatic logic signed [12:0] act_total(input blk_t b);
    int  t;
    byte v;
    t = 0;
    for (int i = 0; i < q4bd_pkg::BLOCK_ELEMENTS; i++) begin
      v = b.act[i / 8][(i % 8) * 8 +: 8];
      t += v;
    end
    return 13'(t);
  endfunction

  function automatic blk_t mk_blk(input logic [63:0] nlo, input logic [63:0] nhi,
                                  input logic [63:0] a0, input logic [63:0] a1,
                                  input logic [63:0] a2, input logic [63:0] a3,
                                  input int asum, input logic [31:0] scale,
                                  input logic last);
    blk_t b;
    b.nib_lo = nlo;
    b.nib_hi = nhi;
    b.act[0] = a0;
    b.act[1] = a1;
    b.act[2] = a2;
    b.act[3] = a3;
    b.asum   = 13'(asum);
    b.scale  = scale;
    b.last   = last;
    return b;
  endfunction

  function automatic blk_t rand_blk(input logic last);
    blk_t b;
    int   mode;
    int   tmp;
    mode     = $urandom_range(9, 0);
    b.nib_lo = {$urandom, $urandom};
    b.nib_hi = {$urandom, $urandom};
    if (mode == 0) begin
      b.nib_lo = '1;
      b.nib_hi = '1;
    end else if (mode == 1) begin
      b.nib_lo = '0;
      b.nib_hi = '0;
    end
    for (int k = 0; k < 4; k++) begin
      b.act[k] = {$urandom, $urandom};
      if (mode == 2) b.act[k] = {8{8'h7f}};
      if (mode == 3) b.act[k] = {8{8'h80}};
    end
    // mostly a matching sum, sometimes an arbitrary one
    if ($urandom_range(3, 0) != 0) begin
      b.asum = act_total(b);
    end else begin
      tmp    = $urandom_range(8160, 0);
      b.asum = 13'(tmp - 4096);
    end
    case ($urandom_range(7, 0))
      0:       b.scale = 32'h8000_0000;
      1:       b.scale = 32'h7fff_ffff;
      2:       b.scale = 32'($urandom_range(1 << 25, 0)) - 32'(1 << 24);
      default: b.scale = $urandom;
    endcase
    b.last = last;
    return b;
  endfunction

  task automatic push_block(input blk_t b);
    while ($urandom_range(99, 0) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, b.scale, b.asum, b.act[3], b.act[2], b.act[1], b.act[0],
                      b.nib_hi, b.nib_lo};
    s_axis_tlast  <= b.last;
    do @(posedge clk_i); while (!s_axis_tready);
    accumulate_block(b);
  endtask

  task automatic wait_rows_done();
    s_axis_tvalid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic test_directed();
    blk_t b;
    idle_pct  = 0;
    stall_pct = 0;
    push_block(mk_blk('0, '0, '0, '0, '0, '0, 0, '0, 1'b1));
    // full nibbles, extreme activations and scales, two positive products in one row
    push_block(mk_blk('1, '1, {8{8'h7f}}, {8{8'h7f}}, {8{8'h7f}}, {8{8'h7f}},
                      4064, 32'h7fff_ffff, 1'b0));
    push_block(mk_blk('1, '1, {8{8'h80}}, {8{8'h80}}, {8{8'h80}}, {8{8'h80}},
                      -4096, 32'h8000_0000, 1'b1));
    // nibble-to-element mapping
    b = mk_blk(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
               64'h0102_0304_0506_0708, 64'hf0e0_d0c0_b0a0_9080,
               64'h1122_3344_5566_7788, 64'h99aa_bbcc_ddee_ff00, 0, 32'h0100_0000, 1'b1);
    b.asum = act_total(b);
    push_block(b);
    push_block(mk_blk(64'h0000_0000_0000_00f0, '0, '0, '0, 64'h1, '0,
                      1, 32'h0100_0000, 1'b1));
    push_block(mk_blk('0, 64'h5000_0000_0000_0000, '0, '0, '0,
                      64'h8100_0000_0000_0000, 0, 32'h0000_0001, 1'b1));
    // activation sum that does not match the activations
    push_block(mk_blk('0, '0, '0, '0, '0, '0, -4096, 32'h0100_0000, 1'b0));
    push_block(mk_blk('0, '0, '0, '0, '0, '0, 4064, 32'hffff_ffff, 1'b0));
    push_block(mk_blk('1, '0, {8{8'h01}}, '0, '0, '0, 1, 32'h7fff_ffff, 1'b1));
    // zero scale
    push_block(mk_blk('1, '1, {8{8'h7f}}, '0, '0, '0, -4096, '0, 1'b1));
    // back-to-back single-block rows
    repeat (5) push_block(rand_blk(1'b1));
    wait_rows_done();
  endtask

  task automatic test_large_rows();
    blk_t up_blk;
    blk_t dn_blk;
    idle_pct  = 0;
    stall_pct = 0;
    // dot = -93952; with the most negative scale the product is positive
    up_blk = mk_blk('1, '1, {8{8'h80}}, {8{8'h80}}, {8{8'h80}}, {8{8'h80}},
                    4064, 32'h8000_0000, 1'b0);
    dn_blk = up_blk;
    dn_blk.scale = 32'h7fff_ffff;
    repeat (23) push_block(up_blk);
    up_blk.last = 1'b1;
    push_block(up_blk);
    repeat (23) push_block(dn_blk);
    dn_blk.last = 1'b1;
    push_block(dn_blk);
    // flag must stay clear on the next row
    push_block(rand_blk(1'b1));
    wait_rows_done();
  endtask

  task automatic test_random_traffic(input int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
      for (int j = 0; j < len; j++) push_block(rand_blk(j == len - 1));
      sent += len;
    end
  endtask

  task automatic test_idle_phases();
    idle_pct  = 0;
    stall_pct = 0;
    test_random_traffic(280);
    idle_pct  = 58;
    stall_pct = 0;
    test_random_traffic(270);
    // let the pipe run dry once mid-stream
    wait_rows_done();
    idle_pct  = 0;
    stall_pct = 58;
    test_random_traffic(270);
    idle_pct  = 6;
    stall_pct = 6;
    test_random_traffic(270);
    wait_rows_done();
  endtask

  // receiver backpressure
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99, 0) >= stall_pct);
  end

  // row result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_rows.size() == 0) begin
        $display("%0t: unexpected row result: expected none, actual row_sum %h saturated %b",
                 $time, m_axis_tdata, m_axis_tuser);
        mismatch_cnt++;
      end else begin
        exp_row = pending_rows.pop_front();
        if (m_axis_tdata !== exp_row.row_sum) begin
          $display("%0t: row_sum mismatch: expected %h, actual %h",
                   $time, exp_row.row_sum, m_axis_tdata);
          mismatch_cnt++;
        end
        if (m_axis_tuser !== exp_row.sat) begin
          $display("%0t: saturated mismatch: expected %b, actual %b",
                   $time, exp_row.sat, m_axis_tuser);
          mismatch_cnt++;
        end
      end
    end
  end

  // watchdog: cycles with no request moving on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("q4_block_dot_row_accumulator_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_large_rows();
    test_idle_phases();
    wait_rows_done();
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_rows.size() == 0) begin
      $display("q4_block_dot_row_accumulator_tb: clean");
    end else begin
      $display("q4_block_dot_row_accumulator_tb: errors");
    end
    $finish;
  end

endmodule
